// ===== design/btx_pkg.sv =====
`timescale 1ns / 1ps

package btx_pkg;

    // Table and stack sizes.
    localparam int NUM_NODES    = 64;
    localparam int MAX_CHILDREN = 8;
    localparam int STACK_DEPTH  = 16;

    // Field widths.
    localparam int NODE_W   = 6;
    localparam int KIND_W   = 2;
    localparam int CNT_W    = 4;
    localparam int SLOT_W   = 3;
    localparam int ST_W     = 2;
    localparam int OP_W     = 2;
    localparam int EV_W     = 2;
    localparam int ERR_W    = 2;
    localparam int CHILD_AW = NODE_W + SLOT_W;
    localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);
    localparam int TOP_W    = $clog2(STACK_DEPTH);
    localparam int IN_W     = 24;
    localparam int OUT_W    = 16;

    // Operation codes carried in s_tuser.
    localparam logic [OP_W-1:0] OP_WRITE_NODE  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_CHILD = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK        = 2'd2;
    localparam logic [OP_W-1:0] OP_RESULT      = 2'd3;

    // Node kinds.
    localparam logic [KIND_W-1:0] KIND_SEQUENCE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FALLBACK = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_SUCCESS = 2'd0;
    localparam logic [ST_W-1:0] ST_FAILURE = 2'd1;
    localparam logic [ST_W-1:0] ST_RUNNING = 2'd2;

    // Event codes carried in m_tuser.
    localparam logic [EV_W-1:0] EV_ACTION   = 2'd0;
    localparam logic [EV_W-1:0] EV_FINISHED = 2'd1;
    localparam logic [EV_W-1:0] EV_ERROR    = 2'd2;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNEXPECTED = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_in;
        logic              push_root;
        logic              rd;
        logic              pop;
        logic              set_last;
        logic [ST_W-1:0]   last_val;
        logic              descend;
        logic              clear_stack;
        logic              set_await;
        logic              clr_await;
        logic              emit;
        logic [EV_W-1:0]   ev;
        logic [ST_W-1:0]   st;
        logic [ERR_W-1:0]  err;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              depth_zero;
        logic              full;
        logic              awaiting;
        logic [KIND_W-1:0] kind;
        logic              pos_zero;
        logic              pos_ge_cnt;
        logic [ST_W-1:0]   last_status;
        logic              out_free;
    } stat_t;

endpackage

// ===== design/behavior_tree_executor.sv =====
`timescale 1ns / 1ps
// Table writes are taken in the idle state. A tick or an action result is accepted in
// the idle state, then each stack frame visited passes a read state (registered node
// and child table read) and an evaluation state; an empty stack closes the walk.
// One item is handled at a time; the next is taken once the result register is free.
// Reset (rst_n low, asynchronous) empties the stack, clears the last status, the
// awaiting flag and root_node; the node and child tables keep no reset value.

module behavior_tree_executor
    import btx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // [5:0] node_index, [7:6] node_kind, [11:8] number of children, [14:12] child_slot,
    // [20:15] child_node, [22:21] action_status
    input  logic [IN_W-1:0]   s_tdata,
    // [1:0] operation
    input  logic [OP_W-1:0]   s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [5:0] action_node, [7:6] tick_status, [9:8] error_code
    output logic [OUT_W-1:0]  m_tdata,
    // [1:0] event_res
    output logic [EV_W-1:0]   m_tuser,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [NODE_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // The root register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    btx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_op     (s_tuser),
        .in_status (s_tdata[22:21]),
        .stat      (stat),
        .cmd       (cmd)
    );

    btx_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== design/btx_ctrl.sv =====
`timescale 1ns / 1ps

module btx_ctrl
    import btx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [OP_W-1:0]   in_op,
    input  logic [ST_W-1:0]   in_status,
    input  stat_t             stat,
    output cmd_t              cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       is_seq;
    logic       is_fb;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;
    assign is_seq   = (stat.kind == KIND_SEQUENCE);
    assign is_fb    = (stat.kind == KIND_FALLBACK);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.load_in = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_TICK)
                    begin
                        if (stat.awaiting)
                        begin
                            cmd.emit = 1'b1;
                            cmd.ev   = EV_ERROR;
                            cmd.err  = ERR_UNEXPECTED;
                        end
                        else
                        begin
                            cmd.push_root = stat.depth_zero;
                            state_next    = S_READ;
                        end
                    end
                    else if (in_op == OP_RESULT)
                    begin
                        if (!stat.awaiting || in_status > ST_RUNNING)
                        begin
                            cmd.emit = 1'b1;
                            cmd.ev   = EV_ERROR;
                            cmd.err  = ERR_UNEXPECTED;
                        end
                        else if (in_status == ST_RUNNING)
                        begin
                            cmd.clr_await = 1'b1;
                            cmd.emit      = 1'b1;
                            cmd.ev        = EV_FINISHED;
                            cmd.st        = ST_RUNNING;
                        end
                        else
                        begin
                            cmd.clr_await = 1'b1;
                            cmd.set_last  = 1'b1;
                            cmd.last_val  = in_status;
                            cmd.pop       = 1'b1;
                            state_next    = S_READ;
                        end
                    end
                end
            end
            S_READ:
            begin
                // An empty stack ends the tick; otherwise fetch the top frame's entries.
                if (stat.depth_zero)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ev     = EV_FINISHED;
                    cmd.st     = stat.last_status;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!is_seq && !is_fb)
                begin
                    // Execution node: request its action.
                    cmd.set_await = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.ev        = EV_ACTION;
                    state_next    = S_IDLE;
                end
                else if (!stat.pos_zero &&
                         stat.last_status == (is_seq ? ST_FAILURE : ST_SUCCESS))
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_READ;
                end
                else if (stat.pos_ge_cnt)
                begin
                    cmd.set_last = 1'b1;
                    cmd.last_val = is_seq ? ST_SUCCESS : ST_FAILURE;
                    cmd.pop      = 1'b1;
                    state_next   = S_READ;
                end
                else if (stat.full)
                begin
                    cmd.clear_stack = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.ev          = EV_ERROR;
                    cmd.err         = ERR_OVERFLOW;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.descend = 1'b1;
                    state_next  = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/btx_dp.sv =====
`timescale 1ns / 1ps

module btx_dp
    import btx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic [OP_W-1:0]   s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    output logic [EV_W-1:0]   m_tuser,
    input  logic              cfg_valid,
    input  logic [NODE_W-1:0] cfg_data,
    input  cmd_t              cmd,
    output stat_t             stat
);

    // Input fields.
    logic [NODE_W-1:0] in_node;
    logic [KIND_W-1:0] in_kind;
    logic [CNT_W-1:0]  in_count;
    logic [SLOT_W-1:0] in_slot;
    logic [NODE_W-1:0] in_child;
    logic [CNT_W-1:0]  cnt_clamp;

    assign in_node  = s_tdata[5:0];
    assign in_kind  = s_tdata[7:6];
    assign in_count = s_tdata[11:8];
    assign in_slot  = s_tdata[14:12];
    assign in_child = s_tdata[20:15];
    assign cnt_clamp = (in_count > CNT_W'(MAX_CHILDREN)) ? CNT_W'(MAX_CHILDREN) : in_count;

    // Table memories and their registered read data.
    logic [KIND_W+CNT_W-1:0] kc_mem [NUM_NODES];
    logic [NODE_W-1:0]       child_mem [NUM_NODES*MAX_CHILDREN];
    logic [KIND_W+CNT_W-1:0] kc_rd;
    logic [NODE_W-1:0]       child_rd;

    // Frame stack.
    logic [NODE_W-1:0]  frame_node_reg [STACK_DEPTH];
    logic [CNT_W-1:0]   frame_pos_reg  [STACK_DEPTH];
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [ST_W-1:0]    last_reg;
    logic [ST_W-1:0]    last_next;
    logic               await_reg;
    logic               await_next;
    logic [NODE_W-1:0]  root_reg;
    logic [NODE_W-1:0]  root_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [OUT_W-1:0]   out_data_reg;
    logic [EV_W-1:0]    out_ev_reg;

    logic [TOP_W-1:0]   top_idx;
    logic [TOP_W-1:0]   push_idx;
    logic [NODE_W-1:0]  top_node;
    logic [CNT_W-1:0]   top_pos;
    logic [NODE_W-1:0]  act_node;
    logic [ST_W-1:0]    out_st;
    logic [ERR_W-1:0]   out_err;

    assign top_idx  = TOP_W'(depth_reg - 1'b1);
    assign push_idx = depth_reg[TOP_W-1:0];
    assign top_node = frame_node_reg[top_idx];
    assign top_pos  = frame_pos_reg[top_idx];

    // Node entry memory: written by node writes, read for the top frame.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in && s_tuser == OP_WRITE_NODE)
        begin
            kc_mem[in_node] <= {in_kind, cnt_clamp};
        end
        if (cmd.rd)
        begin
            kc_rd <= kc_mem[top_node];
        end
    end

    // Child slot memory.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in && s_tuser == OP_WRITE_CHILD)
        begin
            child_mem[{in_node, in_slot}] <= in_child;
        end
        if (cmd.rd)
        begin
            child_rd <= child_mem[{top_node, top_pos[SLOT_W-1:0]}];
        end
    end

    // Frame contents: root push, position advance and child push.
    always_ff @(posedge clk)
    begin
        if (cmd.push_root)
        begin
            frame_node_reg[0] <= root_reg;
            frame_pos_reg[0]  <= '0;
        end
        if (cmd.descend)
        begin
            frame_pos_reg[top_idx]   <= CNT_W'(top_pos + 1'b1);
            frame_node_reg[push_idx] <= child_rd;
            frame_pos_reg[push_idx]  <= '0;
        end
    end

    // Control state next values.
    always_comb
    begin
        depth_next     = depth_reg;
        last_next      = last_reg;
        await_next     = await_reg;
        root_next      = root_reg;
        out_valid_next = out_valid_reg;
        if (cfg_valid)
        begin
            root_next = cfg_data;
        end
        if (cmd.push_root)
        begin
            depth_next = DEPTH_W'(1);
        end
        if (cmd.pop && depth_reg != '0)
        begin
            depth_next = DEPTH_W'(depth_reg - 1'b1);
        end
        if (cmd.descend)
        begin
            depth_next = DEPTH_W'(depth_reg + 1'b1);
        end
        if (cmd.clear_stack)
        begin
            depth_next = '0;
        end
        if (cmd.set_last)
        begin
            last_next = cmd.last_val;
        end
        if (cmd.set_await)
        begin
            await_next = 1'b1;
        end
        if (cmd.clr_await)
        begin
            await_next = 1'b0;
        end
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            last_reg      <= ST_SUCCESS;
            await_reg     <= 1'b0;
            root_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            last_reg      <= last_next;
            await_reg     <= await_next;
            root_reg      <= root_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload: fields that do not belong to the event read as zero.
    assign act_node = (cmd.ev == EV_ACTION) ? top_node : '0;
    assign out_st   = (cmd.ev == EV_FINISHED) ? cmd.st : ST_SUCCESS;
    assign out_err  = (cmd.ev == EV_ERROR) ? cmd.err : ERR_NONE;

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= {6'd0, out_err, out_st, act_node};
            out_ev_reg   <= cmd.ev;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ev_reg;

    // Status towards the controller.
    always_comb
    begin
        stat             = '0;
        stat.depth_zero  = (depth_reg == '0);
        stat.full        = (depth_reg == DEPTH_W'(STACK_DEPTH));
        stat.awaiting    = await_reg;
        stat.kind        = kc_rd[KIND_W+CNT_W-1:CNT_W];
        stat.pos_zero    = (top_pos == '0);
        stat.pos_ge_cnt  = (top_pos >= kc_rd[CNT_W-1:0]);
        stat.last_status = last_reg;
        stat.out_free    = !out_valid_reg || m_tready;
    end

endmodule

// ===== design/btx_checker.sv =====
`timescale 1ns / 1ps

module btx_checker
    import btx_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [OP_W-1:0]  s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic [EV_W-1:0]  m_tuser
);

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only the three defined events appear.
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == EV_ACTION || m_tuser == EV_FINISHED || m_tuser == EV_ERROR))
        else $error("undefined event code");

    // An action request carries no status and no error.
    a_action_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == EV_ACTION |-> m_tdata[9:6] == 4'd0)
        else $error("action request with status or error bits");

    // An error names a cause and no node.
    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == EV_ERROR |-> m_tdata[9:8] != ERR_NONE && m_tdata[5:0] == 6'd0)
        else $error("error event without a cause");

    // A table write transaction never raises a new result.
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_WRITE_NODE || s_tuser == OP_WRITE_CHILD)
        |=> !$rose(m_tvalid))
        else $error("table write produced a result");

endmodule

bind behavior_tree_executor btx_checker u_btx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
